// File: hdl/dense_sigmoid_two_layer_net_macros.svh
// ----------------------------------------------------------------------------
// dense_sigmoid_two_layer_net_macros.svh
// Assertion helpers shared by the network RTL (expect clk and rst_n in scope).
// ----------------------------------------------------------------------------
`ifndef DENSE_SIGMOID_TWO_LAYER_NET_MACROS_SVH
`define DENSE_SIGMOID_TWO_LAYER_NET_MACROS_SVH

// same-cycle implication
`define DSN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsn: same-cycle check failed");

// next-cycle implication
`define DSN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsn: next-cycle check failed");

`endif

// File: hdl/dsn_pkg.sv
// ----------------------------------------------------------------------------
// dsn_pkg
// Sizes, command codes, pipeline records and the sigmoid table of the network.
// ----------------------------------------------------------------------------
`default_nettype none

package dsn_pkg;

    localparam int LATENT_SIZE = 32;
    localparam int HIDDEN_SIZE = 256;
    localparam int OUTPUT_SIZE = 2352;
    localparam int TABLE_DEPTH = 1024;

    localparam int CMD_W  = 3;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 8;
    localparam int DATA_W = 16;
    localparam int ACC_W  = 40;

    localparam int LAT_AW = (LATENT_SIZE > 1) ? $clog2(LATENT_SIZE) : 1;
    localparam int HID_AW = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int OUT_AW = (OUTPUT_SIZE > 1) ? $clog2(OUTPUT_SIZE) : 1;
    localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int W1_DEPTH = HIDDEN_SIZE * LATENT_SIZE;
    localparam int W2_DEPTH = OUTPUT_SIZE * HIDDEN_SIZE;
    localparam int W1_AW = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
    localparam int W2_AW = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
    localparam int CNT_W = (LAT_AW > HID_AW) ? LAT_AW : HID_AW;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh80_0000_0000;
    localparam logic signed [ACC_W-1:0] ARG_HI  = 40'sh00_3FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ARG_LO  = 40'shFF_C000_0000;
    localparam logic signed [ACC_W-1:0] ARG_OFS = 40'sh00_4000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_W1_WR  = 3'd0,
        CMD_B1_WR  = 3'd1,
        CMD_W2_WR  = 3'd2,
        CMD_B2_WR  = 3'd3,
        CMD_LAT_WR = 3'd4,
        CMD_HIDDEN = 3'd5,
        CMD_QUERY  = 3'd6
    } cmd_e;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             done;
        logic             to_out;
        logic [ROW_W-1:0] row;
    } mac_tag_t;

    typedef struct packed {
        logic              valid;
        logic              done;
        logic              to_out;
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] value;
    } mac_res_t;

    typedef logic [DATA_W-1:0] sig_table_t [TABLE_DEPTH];

    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [DATA_W-1:0] sig_entry(int unsigned k);
        logic [63:0]         one;
        logic [63:0]         pos;
        logic [63:0]         half;
        logic [63:0]         y;
        logic [63:0]         f;
        logic [63:0]         t;
        logic [63:0]         eu;
        logic [63:0]         d;
        logic [63:0]         num;
        logic [127:0]        prod;
        logic signed [65:0]  e;
        logic                neg;
        one  = 64'd1 << 32;
        pos  = udiv64(64'(2 * k + 1) << 35, 64'(TABLE_DEPTH));
        half = 64'd1 << 35;
        neg  = (pos < half);
        y    = neg ? (half - pos) : (pos - half);
        f    = y >> 3;
        t    = one;
        e    = 66'sd4294967296;
        for (int n = 1; n < 16; n++)
        begin
            prod = 128'(t) * 128'(f);
            t    = udiv64(64'(prod >> 32), 64'(n));
            if ((n & 1) == 1)
                e = e - $signed({2'b00, t});
            else
                e = e + $signed({2'b00, t});
        end
        if (e < 0)
            e = '0;
        eu = e[63:0];
        for (int n = 0; n < 3; n++)
        begin
            prod = 128'(eu) * 128'(eu);
            eu   = prod[95:32];
        end
        d   = one + eu;
        num = neg ? (eu * 64'd32768) : (64'd1 << 47);
        return DATA_W'(udiv64(num + (d >> 1), d));
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t tbl;
        for (int k = 0; k < TABLE_DEPTH; k++)
            tbl[k] = sig_entry(k);
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// File: hdl/dsn_ram.sv
// ----------------------------------------------------------------------------
// dsn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/dsn_mac.sv
// ----------------------------------------------------------------------------
// dsn_mac
// Multiply-accumulate with 40-bit saturation, argument clamp and sigmoid lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module dsn_mac (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire dsn_pkg::mac_tag_t                    in_tag,
    input  wire logic signed [dsn_pkg::DATA_W-1:0]    weight,
    input  wire logic        [dsn_pkg::DATA_W-1:0]    act,
    input  wire logic signed [dsn_pkg::DATA_W-1:0]    bias,
    output dsn_pkg::mac_res_t                         res
);
    import dsn_pkg::*;

    mac_tag_t                 s1_tag_reg;
    mac_tag_t                 fin_tag_reg;
    mac_tag_t                 idx_tag_reg;
    mac_tag_t                 out_tag_reg;
    logic signed [32:0]       prod_reg;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [TBL_AW-1:0]        idx_reg;
    logic [TBL_AW-1:0]        idx_next;
    logic [DATA_W-1:0]        val_reg;

    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  clamped;
    logic [ACC_W-1:0]         shifted;
    logic [43:0]              scaled;

    always_comb
    begin
        base = s1_tag_reg.first ? {{(ACC_W-DATA_W-15){bias_reg[DATA_W-1]}}, bias_reg, 15'd0}
                                : acc_reg;
        sum  = {base[ACC_W-1], base} + {{(ACC_W-32){prod_reg[32]}}, prod_reg};
        if (sum[ACC_W] != sum[ACC_W-1])
            acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            acc_next = sum[ACC_W-1:0];
    end

    always_comb
    begin
        if (acc_reg > ARG_HI)
            clamped = ARG_HI;
        else if (acc_reg < ARG_LO)
            clamped = ARG_LO;
        else
            clamped = acc_reg;
        shifted  = clamped + ARG_OFS;
        scaled   = 44'(shifted[30:0]) * 44'(TABLE_DEPTH);
        idx_next = scaled[31 +: TBL_AW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg  <= '0;
            fin_tag_reg <= '0;
            idx_tag_reg <= '0;
            out_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg  <= in_tag;
            fin_tag_reg <= s1_tag_reg.valid && s1_tag_reg.last ? s1_tag_reg : '0;
            idx_tag_reg <= fin_tag_reg;
            out_tag_reg <= idx_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * $signed({1'b0, act});
        bias_reg <= bias;
        if (s1_tag_reg.valid)
            acc_reg <= acc_next;
        if (fin_tag_reg.valid)
            idx_reg <= idx_next;
        val_reg <= SIG_TABLE[idx_reg];
    end

    assign res.valid  = out_tag_reg.valid;
    assign res.done   = out_tag_reg.done;
    assign res.to_out = out_tag_reg.to_out;
    assign res.row    = out_tag_reg.row;
    assign res.value  = val_reg;

endmodule

`default_nettype wire

// File: hdl/dense_sigmoid_two_layer_net.sv
// ----------------------------------------------------------------------------
// dense_sigmoid_two_layer_net
// Two dense layers with sigmoid activation, weights held in on-chip RAMs.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low.
// Load requests (weights, biases, latent elements) write their store in that
// cycle and leave busy low, so one load can follow every cycle.
// A hidden-layer request raises busy while it runs, with one
// multiply-accumulate per cycle, bound by the single read port of the
// first-layer weight RAM.
// An output query raises busy while it runs, with one product per
// cycle from the second-layer weight RAM. Its result shows on out_index and
// out_value with out_valid high for one cycle, and busy falls on the
// following edge.
// A query beyond the last output unit and the unused command are dropped.
// The receiver cannot stall; out_valid is a single-cycle strobe.
// Reset clears the sequencer and the MAC pipeline tags only; stores hold no value until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dense_sigmoid_two_layer_net_macros.svh"

module dense_sigmoid_two_layer_net (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic        [dsn_pkg::CMD_W-1:0]     command,
    input  wire logic        [dsn_pkg::ROW_W-1:0]     row_index,
    input  wire logic        [dsn_pkg::COL_W-1:0]     col_index,
    input  wire logic signed [dsn_pkg::DATA_W-1:0]    data_value,
    output logic                                      busy,
    output logic                                      out_valid,
    output logic             [dsn_pkg::ROW_W-1:0]     out_index,
    output logic             [dsn_pkg::DATA_W-1:0]    out_value
);
    import dsn_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic             to_out_reg, to_out_next;
    mac_tag_t         issue_tag_reg, issue_tag_next;

    logic accept;
    logic w1_we, b1_we, w2_we, b2_we, lat_we;
    logic start_hidden, start_query;
    logic col_last;
    logic row_last;

    logic [DATA_W-1:0] w1_rdata, b1_rdata, w2_rdata, b2_rdata, lat_rdata, hid_rdata;
    logic [W1_AW-1:0]  w1_waddr, w1_raddr;
    logic [W2_AW-1:0]  w2_waddr, w2_raddr;
    logic              hid_we;

    logic signed [DATA_W-1:0] mac_weight;
    logic        [DATA_W-1:0] mac_act;
    logic signed [DATA_W-1:0] mac_bias;
    mac_res_t                 res;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        w1_we        = 1'b0;
        b1_we        = 1'b0;
        w2_we        = 1'b0;
        b2_we        = 1'b0;
        lat_we       = 1'b0;
        start_hidden = 1'b0;
        start_query  = 1'b0;
        unique case (cmd_e'(command))
            CMD_W1_WR:
                w1_we = accept && (13'(row_index) < 13'(HIDDEN_SIZE))
                               && (9'(col_index) < 9'(LATENT_SIZE));
            CMD_B1_WR:
                b1_we = accept && (13'(row_index) < 13'(HIDDEN_SIZE));
            CMD_W2_WR:
                w2_we = accept && (13'(row_index) < 13'(OUTPUT_SIZE))
                               && (11'(col_index) < 11'(HIDDEN_SIZE));
            CMD_B2_WR:
                b2_we = accept && (13'(row_index) < 13'(OUTPUT_SIZE));
            CMD_LAT_WR:
                lat_we = accept && (9'(col_index) < 9'(LATENT_SIZE));
            CMD_HIDDEN:
                start_hidden = accept;
            CMD_QUERY:
                start_query = accept && (13'(row_index) < 13'(OUTPUT_SIZE));
            default:
                ;
        endcase
    end

    assign w1_waddr = W1_AW'(W1_AW'(row_index) * W1_AW'(LATENT_SIZE) + W1_AW'(col_index));
    assign w2_waddr = W2_AW'(W2_AW'(row_index) * W2_AW'(HIDDEN_SIZE) + W2_AW'(col_index));
    assign w1_raddr = W1_AW'(W1_AW'(row_reg[HID_AW-1:0]) * W1_AW'(LATENT_SIZE)
                             + W1_AW'(col_reg[LAT_AW-1:0]));
    assign w2_raddr = W2_AW'(W2_AW'(row_reg[OUT_AW-1:0]) * W2_AW'(HIDDEN_SIZE)
                             + W2_AW'(col_reg[HID_AW-1:0]));

    assign col_last = to_out_reg ? (32'(col_reg) == HIDDEN_SIZE - 1)
                                 : (32'(col_reg) == LATENT_SIZE - 1);
    assign row_last = to_out_reg || (32'(row_reg) == HIDDEN_SIZE - 1);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        to_out_next    = to_out_reg;
        issue_tag_next = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start_hidden || start_query)
                begin
                    state_next  = S_RUN;
                    row_next    = start_query ? row_index : '0;
                    col_next    = '0;
                    to_out_next = start_query;
                end
            end
            S_RUN:
            begin
                issue_tag_next.valid  = 1'b1;
                issue_tag_next.first  = (col_reg == '0);
                issue_tag_next.last   = col_last;
                issue_tag_next.done   = col_last && row_last;
                issue_tag_next.to_out = to_out_reg;
                issue_tag_next.row    = row_reg;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                        state_next = S_DRAIN;
                    else
                        row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (res.valid && res.done)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            to_out_reg    <= 1'b0;
            issue_tag_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            to_out_reg    <= to_out_next;
            issue_tag_reg <= issue_tag_next;
        end
    end

    dsn_ram #(.WIDTH(DATA_W), .DEPTH(W1_DEPTH)) u_w1 (
        .clk   (clk),
        .we    (w1_we),
        .waddr (w1_waddr),
        .wdata (data_value),
        .raddr (w1_raddr),
        .rdata (w1_rdata)
    );

    dsn_ram #(.WIDTH(DATA_W), .DEPTH(HIDDEN_SIZE)) u_b1 (
        .clk   (clk),
        .we    (b1_we),
        .waddr (row_index[HID_AW-1:0]),
        .wdata (data_value),
        .raddr (row_reg[HID_AW-1:0]),
        .rdata (b1_rdata)
    );

    dsn_ram #(.WIDTH(DATA_W), .DEPTH(W2_DEPTH)) u_w2 (
        .clk   (clk),
        .we    (w2_we),
        .waddr (w2_waddr),
        .wdata (data_value),
        .raddr (w2_raddr),
        .rdata (w2_rdata)
    );

    dsn_ram #(.WIDTH(DATA_W), .DEPTH(OUTPUT_SIZE)) u_b2 (
        .clk   (clk),
        .we    (b2_we),
        .waddr (row_index[OUT_AW-1:0]),
        .wdata (data_value),
        .raddr (row_reg[OUT_AW-1:0]),
        .rdata (b2_rdata)
    );

    dsn_ram #(.WIDTH(DATA_W), .DEPTH(LATENT_SIZE)) u_lat (
        .clk   (clk),
        .we    (lat_we),
        .waddr (LAT_AW'(col_index)),
        .wdata (data_value),
        .raddr (col_reg[LAT_AW-1:0]),
        .rdata (lat_rdata)
    );

    dsn_ram #(.WIDTH(DATA_W), .DEPTH(HIDDEN_SIZE)) u_hid (
        .clk   (clk),
        .we    (hid_we),
        .waddr (res.row[HID_AW-1:0]),
        .wdata (res.value),
        .raddr (col_reg[HID_AW-1:0]),
        .rdata (hid_rdata)
    );

    assign mac_weight = issue_tag_reg.to_out ? w2_rdata  : w1_rdata;
    assign mac_act    = issue_tag_reg.to_out ? hid_rdata : lat_rdata;
    assign mac_bias   = issue_tag_reg.to_out ? b2_rdata  : b1_rdata;

    dsn_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_tag (issue_tag_reg),
        .weight (mac_weight),
        .act    (mac_act),
        .bias   (mac_bias),
        .res    (res)
    );

    assign hid_we    = res.valid && !res.to_out;
    assign out_valid = res.valid && res.to_out;
    assign out_index = res.row;
    assign out_value = res.value;

    `DSN_ASSERT_IMPL(a_result_while_busy, out_valid, busy)
    `DSN_ASSERT_IMPL(a_no_write_on_result, hid_we, !out_valid)
    `DSN_ASSERT_NEXT(a_compute_raises_busy, start && !busy && (command == CMD_HIDDEN), busy)
    `DSN_ASSERT_IMPL(a_idle_pipe_empty, state_reg == S_IDLE, !issue_tag_reg.valid && !res.valid)

endmodule

`default_nettype wire
